>>> rtl/text_glyph_to_rect_generator_top_macros.svh
// Assertion macros used by the checker of the glyph square generator.
`ifndef TEXT_GLYPH_TO_RECT_GENERATOR_TOP_MACROS_SVH
`define TEXT_GLYPH_TO_RECT_GENERATOR_TOP_MACROS_SVH

// Property that must hold in the same cycle, gated by reset.
`define TGR_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tgr_pkg.sv
// Package: types, constants and font ROM of the glyph square generator.
`default_nettype none

package tgr_pkg;

  localparam int COORD_BITS_DEF = 20;
  localparam int FIELD_BITS     = 20;
  localparam int GLYPH_ROWS     = 7;
  localparam int GLYPH_COLS     = 5;
  localparam int GLYPH_CELLS    = GLYPH_ROWS * GLYPH_COLS;
  localparam int PEN_ADVANCE    = 6;
  localparam int COL_BITS       = $clog2(GLYPH_COLS);
  localparam int OFFX_BITS      = 6;   // holds (GLYPH_COLS-1)*15
  localparam int OFFY_BITS      = 7;   // holds (GLYPH_ROWS-1)*15
  localparam int ADV_BITS       = 7;   // holds PEN_ADVANCE*15

  // Character codes
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_GT      = 8'h3e;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CASE_FOLD  = 8'd32;

  localparam logic [5:0] IDX_DIGIT0 = 6'd26;
  localparam logic [5:0] IDX_AT     = 6'd36;
  localparam logic [5:0] IDX_GT     = 6'd37;
  localparam logic [5:0] IDX_DOT    = 6'd38;
  localparam logic [5:0] IDX_MINUS  = 6'd39;
  localparam logic [5:0] IDX_SLASH  = 6'd40;

  typedef struct packed {
    logic [7:0]         ch;
    logic               new_text;
    logic signed [19:0] start_x;
    logic signed [19:0] start_y;
    logic [3:0]         scale;
    logic [31:0]        color;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] rect_x;
    logic signed [19:0] rect_y;
    logic [3:0]         rect_size;
    logic [31:0]        rect_color;
    logic               last;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic out_free;
  } dp_status_t;

  typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_t;

  function automatic glyph_t font_glyph(input logic [5:0] idx);
    glyph_t g;
    unique case (idx)
      6'd0:  g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      6'd1:  g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      6'd2:  g = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      6'd3:  g = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      6'd4:  g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      6'd5:  g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      6'd6:  g = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14};
      6'd7:  g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      6'd8:  g = {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      6'd9:  g = {5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12};
      6'd10: g = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      6'd11: g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      6'd12: g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      6'd13: g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      6'd14: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      6'd15: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      6'd16: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      6'd17: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      6'd18: g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
      6'd19: g = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
      6'd20: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      6'd21: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      6'd22: g = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      6'd23: g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
      6'd24: g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
      6'd25: g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
      6'd26: g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      6'd27: g = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      6'd28: g = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
      6'd29: g = {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
      6'd30: g = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
      6'd31: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
      6'd32: g = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      6'd33: g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
      6'd34: g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      6'd35: g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
      6'd36: g = {5'd14, 5'd17, 5'd23, 5'd21, 5'd23, 5'd16, 5'd14};
      6'd37: g = {5'd16, 5'd8,  5'd4,  5'd2,  5'd4,  5'd8,  5'd16};
      6'd38: g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12};
      6'd39: g = {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
      6'd40: g = {5'd1,  5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd16};
      default: g = '0;
    endcase
    return g;
  endfunction

  // Cell mask in scan order: bit row*COLS+col, col 0 leftmost.
  function automatic logic [GLYPH_CELLS-1:0] glyph_scan(input logic [7:0] ch);
    logic [7:0]             up;
    logic [5:0]             idx;
    logic                   hit;
    glyph_t                 g;
    logic [GLYPH_CELLS-1:0] v;
    up  = (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ? ch - CASE_FOLD : ch;
    hit = 1'b1;
    idx = '0;
    priority if (up >= CH_UPPER_A && up <= CH_UPPER_Z) idx = 6'(up - CH_UPPER_A);
    else if (up >= CH_ZERO && up <= CH_NINE) idx = 6'(up - CH_ZERO) + IDX_DIGIT0;
    else if (up == CH_AT)    idx = IDX_AT;
    else if (up == CH_GT)    idx = IDX_GT;
    else if (up == CH_DOT)   idx = IDX_DOT;
    else if (up == CH_MINUS) idx = IDX_MINUS;
    else if (up == CH_SLASH) idx = IDX_SLASH;
    else hit = 1'b0;
    g = font_glyph(idx);
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
        v[r*GLYPH_COLS + c] = hit & g[r][GLYPH_COLS-1-c];
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tgr_ctrl.sv
// Controller: sequences character load, cell scan and pen advance.
`default_nettype none

module tgr_ctrl import tgr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.rem_zero) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.advance = status.rem_zero;
        cmd.step    = !status.rem_zero && status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/tgr_datapath.sv
// Datapath: pen registers, cell scan counters and the result register.
`default_nettype none

module tgr_datapath import tgr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire dp_cmd_t  cmd,
  input  wire in_item_t in_data,
  input  wire logic     out_stall,
  output dp_status_t    status,
  output logic          out_valid,
  output out_item_t     out_data
);

  typedef logic [COORD_BITS-1:0] coord_t;

  coord_t                 pen_x_r, pen_y_r;
  logic [3:0]             scale_r;
  logic [31:0]            color_r;
  logic [GLYPH_CELLS-1:0] rem_r;
  logic [COL_BITS-1:0]    col_r;
  logic [OFFX_BITS-1:0]   off_x_r;
  logic [OFFY_BITS-1:0]   off_y_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic [3:0]          eff_scale;
  coord_t              cur_x, cur_y;
  logic [ADV_BITS-1:0] adv;
  logic                out_free;

  assign eff_scale = (in_data.scale == 4'd0) ? 4'd1 : in_data.scale;
  assign cur_x     = pen_x_r + coord_t'(off_x_r);
  assign cur_y     = pen_y_r + coord_t'(off_y_r);
  assign adv       = ADV_BITS'(scale_r) * ADV_BITS'(PEN_ADVANCE);
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
      rem_r   <= '0;
    end else if (cmd.load) begin
      if (in_data.new_text) begin
        pen_x_r <= coord_t'($signed(in_data.start_x));
        pen_y_r <= coord_t'($signed(in_data.start_y));
      end
      rem_r <= glyph_scan(in_data.ch);
    end else if (cmd.step) begin
      rem_r <= rem_r >> 1;
    end else if (cmd.advance) begin
      pen_x_r <= pen_x_r + coord_t'(adv);
    end
  end

  // scan position, running offsets, latched scale and colour
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scale_r <= eff_scale;
      color_r <= in_data.color;
      col_r   <= '0;
      off_x_r <= '0;
      off_y_r <= '0;
    end else if (cmd.step) begin
      if (col_r == COL_BITS'(GLYPH_COLS - 1)) begin
        col_r   <= '0;
        off_x_r <= '0;
        off_y_r <= off_y_r + OFFY_BITS'(scale_r);
      end else begin
        col_r   <= col_r + COL_BITS'(1);
        off_x_r <= off_x_r + OFFX_BITS'(scale_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step && rem_r[0]) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && rem_r[0]) begin
      out_data_r.rect_x     <= FIELD_BITS'(cur_x);
      out_data_r.rect_y     <= FIELD_BITS'(cur_y);
      out_data_r.rect_size  <= scale_r;
      out_data_r.rect_color <= color_r;
      out_data_r.last       <= (rem_r[GLYPH_CELLS-1:1] == '0);
    end
  end

  assign status.rem_zero = (rem_r == '0);
  assign status.out_free = out_free;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

`default_nettype wire

>>> rtl/text_glyph_to_rect_generator_top.sv
// Top level of the glyph square generator: controller plus datapath.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data): one text character per
//    transaction. new_text loads the pen from start_x/start_y first.
//  - Output channel (out_valid / out_stall / out_data): one square per set
//    dot of the 5x7 glyph, row by row, leftmost column first; last marks
//    the final square of a character. Space and unknown codes give none.
//  - First square: the character is loaded into the cell mask register,
//    then each set cell scanned is registered into the result register;
//    blank cells scanned ahead of the first set dot delay the first square.
//  - Sequence: a character is loaded, then scanned one glyph cell per cycle
//    while the single result register is free, up to its last set dot (at
//    most 35 cells), and then the pen advances; a blank character is loaded
//    and then only advances the pen.
//  - Only one character is in flight; in_stall is high from acceptance
//    until the pen has advanced. The next character may be taken while the
//    final square still waits in the output register.
//  - Receiver stall: the scan pauses with the square held; nothing is lost.
//  - Reset (rst_n low, synchronous): pen to zero, scan and output cleared.
`default_nettype none

module text_glyph_to_rect_generator_top import tgr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing: idle -> scan cells -> advance pen
  tgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // pen state, glyph cell mask and result register
  tgr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_stall (out_stall),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/tgr_checker.sv
// Port-level checker for the glyph square generator, with its bind.
`default_nettype none

`include "text_glyph_to_rect_generator_top_macros.svh"

module tgr_checker import tgr_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  `TGR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled square changed")
  `TGR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted while busy")
  `TGR_ASSERT_NEXT(a_busy_mid_char, out_valid && !out_stall && !out_data.last, in_stall, "ready before last square")
  `TGR_ASSERT_NOW(a_size_nonzero, !out_valid || out_data.rect_size != 4'd0, "zero square size")

endmodule

bind text_glyph_to_rect_generator_top tgr_checker u_tgr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

>>> sim/tb_text_glyph_to_rect_generator_top.sv
`timescale 1ns / 1ps
// Self-checking bench: streams text characters into the glyph square generator, checks each square.
module tb_text_glyph_to_rect_generator_top;
  import tgr_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 10;
  // Idle time once drained, a little over what the longest character takes.
  localparam int DRAIN_CYCLES = 40;
  // Watchdog time in ns; the worst run stays well under it even with heavy receiver stall.
  localparam int STOP_NS      = 5_000_000;
  localparam logic [7:0] CH_SPACE = 8'h20;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Idle percentages for sender and receiver, changed per test phase
  int in_idle_pct  = 0;
  int out_idle_pct = 0;

  int err_count    = 0;
  int chars_sent   = 0;
  int blanks_sent  = 0;
  int squares_seen = 0;

  // Predictor state: the pen, wrapping at 20 bits like the block
  logic [19:0] pen_x = '0;
  logic [19:0] pen_y = '0;

  // Squares still owed by the block, oldest first
  out_item_t pending_squares[$];

  always #CLK_HALF clk = ~clk;

  text_glyph_to_rect_generator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 5x7 font, row 0 in the top five bits, leftmost dot as each row's MSB.
  function automatic logic [34:0] font_bits(int idx);
    case (idx)
      0:  return {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      1:  return {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      2:  return {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      3:  return {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      4:  return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      5:  return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      6:  return {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14};
      7:  return {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      8:  return {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      9:  return {5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12};
      10: return {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      11: return {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      12: return {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      13: return {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      14: return {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      15: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      16: return {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      17: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      18: return {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
      19: return {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
      20: return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      21: return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      22: return {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      23: return {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
      24: return {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
      25: return {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
      26: return {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      27: return {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      28: return {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
      29: return {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
      30: return {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
      31: return {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
      32: return {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      33: return {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
      34: return {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      35: return {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
      36: return {5'd14, 5'd17, 5'd23, 5'd21, 5'd23, 5'd16, 5'd14};
      37: return {5'd16, 5'd8,  5'd4,  5'd2,  5'd4,  5'd8,  5'd16};
      38: return {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12};
      39: return {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
      40: return {5'd1,  5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd16};
      default: return '0;
    endcase
  endfunction

  // Font slot for a character code, -1 where nothing is drawn.
  function automatic int glyph_of(logic [7:0] code);
    logic [7:0] up;
    up = (code >= CH_LOWER_A && code <= CH_LOWER_Z) ? code - CASE_FOLD : code;
    if (up >= CH_UPPER_A && up <= CH_UPPER_Z) return int'(up - CH_UPPER_A);
    if (up >= CH_ZERO && up <= CH_NINE) return int'(IDX_DIGIT0) + int'(up - CH_ZERO);
    case (up)
      CH_AT:    return int'(IDX_AT);
      CH_GT:    return int'(IDX_GT);
      CH_DOT:   return int'(IDX_DOT);
      CH_MINUS: return int'(IDX_MINUS);
      CH_SLASH: return int'(IDX_SLASH);
      default:  return -1;
    endcase
  endfunction

  // Works out the squares for one accepted character and moves the pen on.
  function automatic void predict_squares(in_item_t it);
    logic [3:0]  dot;
    logic [34:0] bits;
    int          g;
    out_item_t   sq;
    out_item_t   glyph_sq[$];
    dot = (it.scale == 4'd0) ? 4'd1 : it.scale;
    if (it.new_text) begin
      pen_x = it.start_x;
      pen_y = it.start_y;
    end
    g = glyph_of(it.ch);
    if (g >= 0) begin
      bits = font_bits(g);
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        for (int c = 0; c < GLYPH_COLS; c++) begin
          if (bits[34 - GLYPH_COLS * r - c]) begin
            sq.rect_x     = pen_x + 20'(c * dot);
            sq.rect_y     = pen_y + 20'(r * dot);
            sq.rect_size  = dot;
            sq.rect_color = it.color;
            sq.last       = 1'b0;
            glyph_sq.push_back(sq);
          end
        end
      end
      if (glyph_sq.size() > 0) begin
        sq = glyph_sq.pop_back();
        sq.last = 1'b1;
        glyph_sq.push_back(sq);
      end
      foreach (glyph_sq[i]) pending_squares.push_back(glyph_sq[i]);
    end
    pen_x = pen_x + 20'(PEN_ADVANCE * dot);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
    err_count++;
  endtask

  // Result checker and receiver stall. Values read here are the pre-edge
  // ones, so a square counts exactly when the block saw valid and no stall.
  always @(posedge clk) begin : check_squares
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      squares_seen++;
      if (pending_squares.size() == 0) begin
        report_mismatch("square with none expected", 32'(out_data.rect_x), 32'd0);
      end else begin
        want = pending_squares.pop_front();
        if (out_data.rect_x !== want.rect_x)
          report_mismatch("rect_x", 32'(out_data.rect_x), 32'(want.rect_x));
        if (out_data.rect_y !== want.rect_y)
          report_mismatch("rect_y", 32'(out_data.rect_y), 32'(want.rect_y));
        if (out_data.rect_size !== want.rect_size)
          report_mismatch("rect_size", 32'(out_data.rect_size), 32'(want.rect_size));
        if (out_data.rect_color !== want.rect_color)
          report_mismatch("rect_color", out_data.rect_color, want.rect_color);
        if (out_data.last !== want.last)
          report_mismatch("last", 32'(out_data.last), 32'(want.last));
      end
    end
    out_stall <= (int'($urandom_range(99)) < out_idle_pct);
  end

  function automatic in_item_t make_char(logic [7:0] ch, logic nt, logic [19:0] sx,
                                         logic [19:0] sy, logic [3:0] sc, logic [31:0] col);
    in_item_t it;
    it.ch       = ch;
    it.new_text = nt;
    it.start_x  = sx;
    it.start_y  = sy;
    it.scale    = sc;
    it.color    = col;
    return it;
  endfunction

  // One input transaction. Valid is raised at a clock edge and stays up
  // until the block takes the character; the prediction is made then.
  // The sender then idles cycle by cycle at the set rate, with junk on the
  // bus to show it is ignored.
  task automatic send_char(in_item_t it);
    logic [95:0] noise;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_squares(it);
    chars_sent++;
    if (glyph_of(it.ch) < 0) blanks_sent++;
    while (int'($urandom_range(99)) < in_idle_pct) begin
      noise    = {$urandom, $urandom, $urandom};
      in_valid <= 1'b0;
      in_data  <= noise[$bits(in_item_t)-1:0];
      @(posedge clk);
    end
  endtask

  // Right after reset the pen sits at zero; start fields are don't-care here.
  task automatic test_pen_after_reset();
    send_char(make_char(CH_UPPER_A, 1'b0, 20'h12345, 20'h54321, 4'd1, 32'h0000_0000));
    send_char(make_char(CH_LOWER_A + 8'd1, 1'b0, 20'hFFFFF, 20'h00000, 4'd2, 32'hFFFF_FFFF));
  endtask

  // Origins at both ends of the signed range, largest and zero scale,
  // and squares wrapping round the 20-bit coordinate space.
  task automatic test_extreme_origins();
    send_char(make_char(CH_UPPER_A + 8'd22, 1'b1, 20'h80000, 20'h80000, 4'd15, 32'hFFFF_FFFF));
    send_char(make_char(CH_ZERO + 8'd8, 1'b0, 20'h00000, 20'h00000, 4'd15, 32'hA5A5_A5A5));
    send_char(make_char(CH_UPPER_A + 8'd12, 1'b1, 20'h7FFFF, 20'h7FFFF, 4'd15, 32'h0000_0000));
    send_char(make_char(CH_AT, 1'b0, 20'h00000, 20'h00000, 4'd0, 32'h5A5A_5A5A));
    send_char(make_char(CH_LOWER_Z, 1'b1, 20'h7FFF0, 20'hFFFFF, 4'd0, 32'h8000_0001));
  endtask

  // Codes that draw nothing still move the pen; the closing 'H' shows where.
  task automatic test_blank_codes();
    send_char(make_char(8'h00, 1'b1, 20'h00100, 20'h00200, 4'd3, 32'h1111_1111));
    send_char(make_char(CH_SPACE, 1'b0, 20'h0, 20'h0, 4'd0, 32'h2222_2222));
    send_char(make_char(8'h80, 1'b0, 20'h0, 20'h0, 4'd15, 32'h3333_3333));
    send_char(make_char(8'hFF, 1'b0, 20'h0, 20'h0, 4'd7, 32'h4444_4444));
    send_char(make_char(CH_LOWER_Z + 8'd1, 1'b0, 20'h0, 20'h0, 4'd1, 32'h5555_5555));
    send_char(make_char(CH_LOWER_A - 8'd1, 1'b0, 20'h0, 20'h0, 4'd1, 32'h6666_6666));
    send_char(make_char(CH_UPPER_Z + 8'd1, 1'b0, 20'h0, 20'h0, 4'd1, 32'h7777_7777));
    send_char(make_char(CH_UPPER_A + 8'd7, 1'b0, 20'h0, 20'h0, 4'd1, 32'h8888_8888));
  endtask

  // Symbols, digit edges, letter edges and neighbours of the symbol codes.
  task automatic test_symbols_digits();
    send_char(make_char(CH_GT, 1'b1, 20'hFFF00, 20'h00010, 4'd4, 32'hDEAD_BEEF));
    send_char(make_char(CH_DOT, 1'b0, 20'h0, 20'h0, 4'd4, 32'hDEAD_BEEF));
    send_char(make_char(CH_MINUS, 1'b0, 20'h0, 20'h0, 4'd5, 32'hCAFE_F00D));
    send_char(make_char(CH_SLASH, 1'b0, 20'h0, 20'h0, 4'd6, 32'hCAFE_F00D));
    send_char(make_char(CH_ZERO, 1'b0, 20'h0, 20'h0, 4'd8, 32'h0F0F_0F0F));
    send_char(make_char(CH_NINE, 1'b0, 20'h0, 20'h0, 4'd9, 32'hF0F0_F0F0));
    send_char(make_char(CH_UPPER_Z, 1'b0, 20'h0, 20'h0, 4'd10, 32'h1234_5678));
    send_char(make_char(CH_LOWER_A + 8'd8, 1'b0, 20'h0, 20'h0, 4'd11, 32'h8765_4321));
    send_char(make_char(CH_GT + 8'd1, 1'b0, 20'h0, 20'h0, 4'd12, 32'h0000_FFFF));
    send_char(make_char(CH_GT - 8'd1, 1'b0, 20'h0, 20'h0, 4'd13, 32'hFFFF_0000));
  endtask

  // Mostly glyph characters in either case, some spaces, some raw bytes.
  function automatic logic [7:0] random_char();
    int k;
    int g;
    k = $urandom_range(99);
    if (k >= 72) return 8'($urandom);
    if (k >= 60) return CH_SPACE;
    g = $urandom_range(40);
    if (g < 26) return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + 8'(g);
    if (g < 36) return CH_ZERO + 8'(g - 26);
    case (g)
      36:      return CH_AT;
      37:      return CH_GT;
      38:      return CH_DOT;
      39:      return CH_MINUS;
      default: return CH_SLASH;
    endcase
  endfunction

  // Origins biased toward both ends of the range so the sums wrap often.
  function automatic logic [19:0] random_coord();
    case ($urandom_range(3))
      0:       return 20'h80000 + 20'($urandom_range(63));
      1:       return 20'h7FFFF - 20'($urandom_range(127));
      default: return 20'($urandom);
    endcase
  endfunction

  // Random strings: each word opens with new_text and keeps its scale and
  // colour, with the odd stray restart or mid-word change mixed in.
  task automatic test_random_text(int n_items, int send_idle, int recv_idle);
    in_item_t    it;
    int          left_in_word;
    logic [3:0]  word_scale;
    logic [31:0] word_color;
    in_idle_pct  = send_idle;
    out_idle_pct = recv_idle;
    left_in_word = 0;
    word_scale   = '0;
    word_color   = '0;
    for (int i = 0; i < n_items; i++) begin
      it.ch       = random_char();
      it.start_x  = random_coord();
      it.start_y  = random_coord();
      it.new_text = 1'b0;
      if (left_in_word == 0) begin
        it.new_text  = 1'b1;
        left_in_word = $urandom_range(1, 8);
        word_scale   = 4'($urandom_range(15));
        word_color   = $urandom;
      end else if ($urandom_range(99) < 5) begin
        it.new_text = 1'b1;
      end
      left_in_word--;
      it.scale = ($urandom_range(99) < 15) ? 4'($urandom_range(15)) : word_scale;
      it.color = ($urandom_range(99) < 15) ? $urandom : word_color;
      send_char(it);
    end
  endtask

  // Stop driving, let every owed square arrive, then idle past the longest
  // character so that any stray extra square is caught.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_squares.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    out_idle_pct = 30;
    test_pen_after_reset();
    test_extreme_origins();
    test_blank_codes();
    test_symbols_digits();

    // Sender dense / receiver busy, then the reverse, then flat out.
    test_random_text(36, 23, 81);
    test_random_text(36, 81, 23);
    test_random_text(33, 0, 0);
    wait_drained();

    $display("Covered %0d characters (%0d drawing nothing) and %0d squares checked.",
             chars_sent, blanks_sent, squares_seen);
    $display("Directed edge cases, then random strings under three stall mixes.");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(STOP_NS);
    $display("timeout with %0d squares outstanding", pending_squares.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
